[rtl/core/lcd_nibble_rotate_register_file_top_macros.svh]
// Assertion macros shared by the display register file.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef LCD_NIBBLE_ROTATE_REGISTER_FILE_TOP_MACROS_SVH
`define LCD_NIBBLE_ROTATE_REGISTER_FILE_TOP_MACROS_SVH

// Checks an implication, with the check held off while reset is asserted.
`define LCDNR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition leads to a consequence in the following cycle.
`define LCDNR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lcdnr_pkg.sv]
package lcdnr_pkg;

  localparam int LCDNR_DIGITS = 12;
  localparam int NIB_W        = 4;
  localparam int ANN_W        = 12;
  localparam int CON_W        = 4;
  localparam int NUM_ROWS     = 3;

  // Operation codes.
  localparam logic [2:0] OP_DISP_WR = 3'd0;
  localparam logic [2:0] OP_DISP_RD = 3'd1;
  localparam logic [2:0] OP_ANN_WR  = 3'd2;
  localparam logic [2:0] OP_CON_WR  = 3'd3;
  localparam logic [2:0] OP_CON_RD  = 3'd4;

  // Modifier codes, named after their display-write meaning.
  localparam logic [3:0] MOD_ROW_A   = 4'd0;
  localparam logic [3:0] MOD_ROW_B   = 4'd1;
  localparam logic [3:0] MOD_ROW_C   = 4'd2;
  localparam logic [3:0] MOD_AB_L6   = 4'd3;
  localparam logic [3:0] MOD_ABC_L4  = 4'd4;
  localparam logic [3:0] MOD_AB_R6   = 4'd5;
  localparam logic [3:0] MOD_ABC_R4  = 4'd6;
  localparam logic [3:0] MOD_A_L1    = 4'd7;
  localparam logic [3:0] MOD_B_L1    = 4'd8;
  localparam logic [3:0] MOD_C_L1    = 4'd9;
  localparam logic [3:0] MOD_A_R1    = 4'd10;
  localparam logic [3:0] MOD_B_R1    = 4'd11;
  localparam logic [3:0] MOD_AB_L1   = 4'd12;
  localparam logic [3:0] MOD_AB_R1   = 4'd13;
  localparam logic [3:0] MOD_ABC_L1  = 4'd14;
  localparam logic [3:0] MOD_ABC_R1  = 4'd15;
  // The same code selects the annunciator read and the contrast access.
  localparam logic [3:0] MOD_SPECIAL = 4'd5;

  // Row selection masks, bit 0 is row A.
  localparam logic [2:0] ROWS_NONE = 3'b000;
  localparam logic [2:0] ROWS_A    = 3'b001;
  localparam logic [2:0] ROWS_B    = 3'b010;
  localparam logic [2:0] ROWS_C    = 3'b100;
  localparam logic [2:0] ROWS_AB   = 3'b011;
  localparam logic [2:0] ROWS_ABC  = 3'b111;
  localparam int         ROW_C_IDX = 2;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic [NUM_ROWS-1:0] shift;   // rows that shift this cycle
    logic                left;    // shift toward nibble 0
    logic                wr;      // insert nibbles from C
    logic                rd;      // capture leaving nibbles into the result
    logic                bit0_c;  // row C keeps only bit 0 of inserted nibbles
    logic                multi;   // rows take interleaved C nibbles
    logic                done;    // result moves to the output register
    logic                busy;    // a request is in work
  } lcdnr_ctl_t;

endpackage

[rtl/core/lcdnr_row.sv]
module lcdnr_row
  import lcdnr_pkg::*;
#(
  parameter int DIGITS = LCDNR_DIGITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  logic             left,
  input  logic [NIB_W-1:0] push_nib,
  output logic [NIB_W-1:0] exit_nib
);

  logic [DIGITS-1:0][NIB_W-1:0] row_r;
  logic [DIGITS-1:0][NIB_W-1:0] row_nxt;

  // A left shift drops nibble 0 and inserts at the top; a right shift the reverse.
  assign exit_nib = left ? row_r[0] : row_r[DIGITS-1];

  always_comb begin
    row_nxt = row_r;
    if (shift_en) begin
      if (left) begin
        row_nxt = {push_nib, row_r[DIGITS-1:1]};
      end else begin
        row_nxt = {row_r[DIGITS-2:0], push_nib};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

endmodule

[rtl/core/lcdnr_seq.sv]
module lcdnr_seq
  import lcdnr_pkg::*;
#(
  parameter int DIGITS = LCDNR_DIGITS,
  parameter int PW     = $clog2(DIGITS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [2:0]    op,
  input  logic [3:0]    modifier,
  input  logic          slot_free,
  output lcdnr_ctl_t    ctl,
  output logic [PW-1:0] ptr
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  localparam logic [PW-1:0] TM1_FULL  = PW'(DIGITS - 1);
  localparam logic [PW-1:0] TM1_HALF  = PW'(DIGITS / 2 - 1);
  localparam logic [PW-1:0] TM1_THIRD = PW'(DIGITS / 3 - 1);
  localparam logic [PW-1:0] TM1_ONE   = '0;

  state_t        state_r;
  logic [2:0]    rows_r;
  logic          left_r;
  logic          wr_r;
  logic          rd_r;
  logic          bit0c_r;
  logic [PW-1:0] tm1_r;
  logic [PW-1:0] cnt_r;
  logic [PW-1:0] ptr_r;

  logic [2:0]    rows_d;
  logic          left_d;
  logic [PW-1:0] tm1_d;
  logic          is_wr;
  logic          is_rd;
  logic [PW-1:0] stride;

  assign is_wr = (op == OP_DISP_WR);
  assign is_rd = (op == OP_DISP_RD);

  always_comb begin
    rows_d = ROWS_NONE;
    left_d = 1'b0;
    tm1_d  = TM1_ONE;
    if (is_wr || is_rd) begin
      case (modifier)
        MOD_ROW_A: begin
          rows_d = ROWS_A; left_d = is_wr; tm1_d = TM1_FULL;
        end
        MOD_ROW_B: begin
          rows_d = ROWS_B; left_d = is_wr; tm1_d = TM1_FULL;
        end
        MOD_ROW_C: begin
          rows_d = ROWS_C; left_d = is_wr; tm1_d = TM1_FULL;
        end
        MOD_AB_L6: begin
          rows_d = ROWS_AB; left_d = is_wr; tm1_d = TM1_HALF;
        end
        MOD_ABC_L4: begin
          rows_d = ROWS_ABC; left_d = is_wr; tm1_d = TM1_THIRD;
        end
        MOD_AB_R6: begin
          // A read with this code returns the annunciators and moves no row.
          rows_d = is_wr ? ROWS_AB : ROWS_NONE; tm1_d = is_wr ? TM1_HALF : TM1_ONE;
        end
        MOD_ABC_R4: begin
          rows_d = is_wr ? ROWS_ABC : ROWS_C; tm1_d = is_wr ? TM1_THIRD : TM1_ONE;
        end
        MOD_A_L1:   begin rows_d = ROWS_A;   left_d = 1'b1; end
        MOD_B_L1:   begin rows_d = ROWS_B;   left_d = 1'b1; end
        MOD_C_L1:   begin rows_d = ROWS_C;   left_d = 1'b1; end
        MOD_A_R1:   begin rows_d = ROWS_A;   end
        MOD_B_R1:   begin rows_d = ROWS_B;   end
        MOD_AB_L1:  begin rows_d = ROWS_AB;  left_d = 1'b1; end
        MOD_AB_R1:  begin rows_d = ROWS_AB;  end
        MOD_ABC_L1: begin rows_d = ROWS_ABC; left_d = 1'b1; end
        MOD_ABC_R1: begin rows_d = ROWS_ABC; end
        default:    begin rows_d = ROWS_NONE; end
      endcase
    end
  end

  // The C nibble pointer advances by the number of rows in the group.
  assign stride = PW'(rows_r[0]) + PW'(rows_r[1]) + PW'(rows_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rows_r  <= ROWS_NONE;
      left_r  <= 1'b0;
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      bit0c_r <= 1'b0;
      tm1_r   <= '0;
      cnt_r   <= '0;
      ptr_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_RUN;
            rows_r  <= rows_d;
            left_r  <= left_d;
            wr_r    <= is_wr;
            rd_r    <= is_rd;
            bit0c_r <= !(is_wr && modifier == MOD_ROW_C);
            tm1_r   <= tm1_d;
            cnt_r   <= '0;
            ptr_r   <= '0;
          end
        end
        S_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          ptr_r <= ptr_r + stride;
          if (cnt_r == tm1_r) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign ptr        = ptr_r;
  assign ctl.shift  = rows_r & {NUM_ROWS{state_r == S_RUN}};
  assign ctl.left   = left_r;
  assign ctl.wr     = wr_r;
  assign ctl.rd     = rd_r;
  assign ctl.bit0_c = bit0c_r;
  assign ctl.multi  = (rows_r == ROWS_AB) || (rows_r == ROWS_ABC);
  assign ctl.done   = (state_r == S_FIN) && slot_free;
  assign ctl.busy   = (state_r != S_IDLE);

endmodule

[rtl/core/lcd_nibble_rotate_register_file_top.sv]
// Display register file for a calculator LCD driver.
// The input channel carries one request per accepted transfer: an operation,
// a 4-bit modifier and the CPU's 12-nibble C register. The result channel
// returns C with the nibbles that a read replaced, plus a flag that is set
// when row, annunciator or contrast content may have changed.
// Each of the three rows is a nibble shift register that moves one nibble
// per cycle, so a request that rotates by t nibbles does so in its shift
// phase (t is 1, 4, 6 or 12; requests that touch no row also pass through
// the shift phase). The result then moves to the output register and
// appears on out_valid, and the next request is taken only after that, once
// the block is back in idle; a request is not taken while another is in work.
// The output register holds a finished result while the receiver stalls;
// the block keeps working on the following request and waits at its end
// only if the previous result has still not been taken.
// Synchronous reset clears all rows, the annunciators, the contrast level
// and the handshake state; no result is pending after reset.
`include "lcd_nibble_rotate_register_file_top_macros.svh"

module lcd_nibble_rotate_register_file_top
  import lcdnr_pkg::*;
#(
  parameter int DIGITS = LCDNR_DIGITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_operation,
  input  logic [3:0]              in_modifier,
  input  logic [NIB_W*DIGITS-1:0] in_c_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [NIB_W*DIGITS-1:0] out_result_value,
  output logic                    out_display_updated
);

  localparam int PW = $clog2(DIGITS);
  localparam int CW = NIB_W * DIGITS;

  lcdnr_ctl_t    ctl;
  logic [PW-1:0] ptr;
  logic          accept;
  logic          slot_free;

  logic [CW-1:0]    c_r;
  logic [CW-1:0]    res_r;
  logic [CW-1:0]    res_nxt;
  logic [CW-1:0]    res_init;
  logic             upd_r;
  logic             upd_d;
  logic [ANN_W-1:0] ann_r;
  logic [CON_W-1:0] con_r;

  logic             out_valid_r;
  logic [CW-1:0]    out_res_r;
  logic             out_upd_r;

  logic [NIB_W-1:0] exit_nib [NUM_ROWS];
  logic [NIB_W-1:0] push_nib [NUM_ROWS];
  logic [NIB_W-1:0] c_nib    [NUM_ROWS];
  logic [PW-1:0]    idx      [NUM_ROWS];

  assign in_stall  = ctl.busy;
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  lcdnr_seq #(
    .DIGITS (DIGITS),
    .PW     (PW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .op        (in_operation),
    .modifier  (in_modifier),
    .slot_free (slot_free),
    .ctl       (ctl),
    .ptr       (ptr)
  );

  // Each row reads or writes the C nibble at the shared pointer; when several
  // rows move together they take neighboring nibbles, row A first.
  for (genvar g = 0; g < NUM_ROWS; g++) begin : g_row
    assign idx[g]   = ptr + (ctl.multi ? PW'(g) : PW'(0));
    assign c_nib[g] = c_r[{idx[g], 2'b00} +: NIB_W];

    always_comb begin
      if (!ctl.wr) begin
        push_nib[g] = exit_nib[g];
      end else if (g == ROW_C_IDX && ctl.bit0_c) begin
        push_nib[g] = c_nib[g] & NIB_W'(8'h01);
      end else begin
        push_nib[g] = c_nib[g];
      end
    end

    lcdnr_row #(
      .DIGITS (DIGITS)
    ) u_row (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (ctl.shift[g]),
      .left     (ctl.left),
      .push_nib (push_nib[g]),
      .exit_nib (exit_nib[g])
    );
  end

  // The result starts as C with the whole-register reads applied at accept.
  always_comb begin
    res_init = in_c_value;
    if (in_operation == OP_DISP_RD && in_modifier == MOD_SPECIAL) begin
      res_init[ANN_W-1:0] = ann_r;
    end
    if (in_operation == OP_CON_RD && in_modifier == MOD_SPECIAL) begin
      res_init[CON_W-1:0] = con_r;
    end
  end

  always_comb begin
    case (in_operation)
      OP_DISP_WR: upd_d = 1'b1;
      OP_DISP_RD: upd_d = !(in_modifier == MOD_ROW_A || in_modifier == MOD_ROW_B ||
                            in_modifier == MOD_ROW_C || in_modifier == MOD_SPECIAL);
      OP_ANN_WR:  upd_d = 1'b1;
      OP_CON_WR:  upd_d = (in_modifier == MOD_SPECIAL);
      default:    upd_d = 1'b0;
    endcase
  end

  // During the shift phase a read drops each leaving row nibble into C.
  always_comb begin
    res_nxt = res_r;
    if (accept) begin
      res_nxt = res_init;
    end else if (ctl.rd) begin
      for (int k = 0; k < NUM_ROWS; k++) begin
        if (ctl.shift[k]) begin
          res_nxt[{idx[k], 2'b00} +: NIB_W] = exit_nib[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      c_r   <= in_c_value;
      upd_r <= upd_d;
    end
    if (ctl.done) begin
      out_res_r <= res_r;
      out_upd_r <= upd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ann_r       <= '0;
      con_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && in_operation == OP_ANN_WR) begin
        ann_r <= in_c_value[ANN_W-1:0];
      end
      if (accept && in_operation == OP_CON_WR && in_modifier == MOD_SPECIAL) begin
        con_r <= in_c_value[CON_W-1:0];
      end
      if (ctl.done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_value    = out_res_r;
  assign out_display_updated = out_upd_r;

  `LCDNR_ASSERT_NEXT(a_accept_busy, accept, in_stall, "accepted request did not start work")
  `LCDNR_ASSERT_IMPL(a_done_slot, ctl.done, slot_free, "result moved into a full output register")
  `LCDNR_ASSERT_IMPL(a_rise_work, $rose(out_valid_r), $past(in_stall),
                     "result appeared without a request in work")

endmodule
